FILE: sv/polygon_face_area_defines.svh
`ifndef POLYGON_FACE_AREA_DEFINES_SVH
`define POLYGON_FACE_AREA_DEFINES_SVH

// same-cycle implication, masked during reset
`define PFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("polygon_face_area check failed");

// next-cycle implication, masked during reset
`define PFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("polygon_face_area check failed");

`endif

FILE: sv/pfa_pkg.sv
package pfa_pkg;

    localparam int PFA_MAX_VERTICES_DEF  = 256;
    localparam int PFA_COORD_BITS_DEF    = 16;
    localparam int PFA_MIN_FACE_VERTICES = 3;

    // accumulator and result width
    localparam int PFA_ACC_BITS = 42;
    localparam int PFA_HALF_W   = PFA_ACC_BITS / 2;
    localparam int PFA_SUM_W    = 2 * PFA_ACC_BITS;
    localparam int PFA_REM_W    = PFA_ACC_BITS + 3;

    // sum of squares: three partial products per component
    localparam int PFA_PP_COUNT   = 9;
    localparam int PFA_SEL_W      = $clog2(PFA_PP_COUNT);
    localparam int PFA_SQ_LAST    = PFA_PP_COUNT + 1;
    localparam int PFA_ROOT_STEPS = PFA_ACC_BITS;
    localparam int PFA_STEP_W     = $clog2(PFA_ROOT_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SQR,
        ST_ROOT,
        ST_OUT
    } pfa_state_t;

    typedef enum logic [1:0] {
        PART_LL,
        PART_HL,
        PART_HH
    } pfa_part_t;

    typedef struct packed {
        logic [1:0] comp;
        pfa_part_t  part;
    } pfa_pp_sel_t;

    typedef struct packed {
        logic                 take_anchor;
        logic                 take_prev;
        logic                 take_diff;
        logic                 mul;
        logic                 acc;
        logic                 sq_clear;
        logic                 mag_load;
        logic                 sq_mul;
        logic [PFA_SEL_W-1:0] sq_sel;
        logic                 sq_add;
        logic                 rt_step;
        logic                 out_load;
        logic                 clear_face;
        logic                 degenerate;
        logic                 overflow;
    } pfa_cmd_t;

    function automatic pfa_pp_sel_t pfa_pp_decode(input logic [PFA_SEL_W-1:0] sel);
        pfa_pp_sel_t r;
        unique case (sel)
            4'd0:    r = '{comp: 2'd0, part: PART_LL};
            4'd1:    r = '{comp: 2'd0, part: PART_HL};
            4'd2:    r = '{comp: 2'd0, part: PART_HH};
            4'd3:    r = '{comp: 2'd1, part: PART_LL};
            4'd4:    r = '{comp: 2'd1, part: PART_HL};
            4'd5:    r = '{comp: 2'd1, part: PART_HH};
            4'd6:    r = '{comp: 2'd2, part: PART_LL};
            4'd7:    r = '{comp: 2'd2, part: PART_HL};
            4'd8:    r = '{comp: 2'd2, part: PART_HH};
            default: r = '{comp: 2'd0, part: PART_LL};
        endcase
        return r;
    endfunction

endpackage

FILE: sv/pfa_ctrl.sv
module pfa_ctrl
    import pfa_pkg::*;
#(
    parameter int MAX_VERTICES = PFA_MAX_VERTICES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     last_vertex,
    input  logic     face_invalid,
    output logic     out_valid,
    input  logic     out_ready,
    output pfa_cmd_t cmd
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 2);

    pfa_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  inv_reg, inv_next;
    logic                  last_reg, last_next;
    logic                  acc_pend_reg, acc_pend_next;
    logic [PFA_STEP_W-1:0] step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PFA_STEP_W-1:0] sel_w;
    logic                  accept;
    logic                  degenerate_w;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            inv_reg       <= 1'b0;
            last_reg      <= 1'b0;
            acc_pend_reg  <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            inv_reg       <= inv_next;
            last_reg      <= last_next;
            acc_pend_reg  <= acc_pend_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign accept       = in_valid && in_ready;
    assign degenerate_w = inv_reg || (cnt_reg < CNT_W'(PFA_MIN_FACE_VERTICES));
    assign sel_w        = step_reg - PFA_STEP_W'(1);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        inv_next      = inv_reg;
        last_next     = last_reg;
        step_next     = step_reg;
        acc_pend_next = (state_reg == ST_MUL);
        cmd           = '0;
        // products from the multiply cycle are accumulated in the following cycle
        cmd.acc       = acc_pend_reg;
        cmd.sq_sel    = sel_w[PFA_SEL_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.take_anchor = (cnt_reg == '0);
                    cmd.take_prev   = (cnt_reg < CNT_W'(MAX_VERTICES));
                    cmd.take_diff   = (cnt_reg >= CNT_W'(2))
                                      && (cnt_reg < CNT_W'(MAX_VERTICES));
                    cnt_next  = (cnt_reg < CNT_W'(MAX_VERTICES))
                                ? cnt_reg + CNT_W'(1) : CNT_W'(MAX_VERTICES + 1);
                    inv_next  = inv_reg | face_invalid;
                    last_next = last_vertex;
                    if (cmd.take_diff)
                        state_next = ST_MUL;
                    else if (last_vertex)
                        state_next = ST_ACC;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = last_reg ? ST_ACC : ST_IDLE;
            end
            ST_ACC:
            begin
                cmd.sq_clear = 1'b1;
                step_next    = '0;
                state_next   = degenerate_w ? ST_OUT : ST_SQR;
            end
            ST_SQR:
            begin
                // step 0 takes magnitudes, then multiply, then add the registered product
                cmd.mag_load = (step_reg == '0);
                cmd.sq_mul   = (step_reg >= PFA_STEP_W'(1))
                               && (step_reg <= PFA_STEP_W'(PFA_PP_COUNT));
                cmd.sq_add   = (step_reg >= PFA_STEP_W'(2));
                if (step_reg == PFA_STEP_W'(PFA_SQ_LAST))
                begin
                    step_next  = '0;
                    state_next = ST_ROOT;
                end
                else
                    step_next = step_reg + PFA_STEP_W'(1);
            end
            ST_ROOT:
            begin
                cmd.rt_step = 1'b1;
                if (step_reg == PFA_STEP_W'(PFA_ROOT_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_OUT;
                end
                else
                    step_next = step_reg + PFA_STEP_W'(1);
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.degenerate = degenerate_w;
                    cmd.overflow   = (cnt_reg == CNT_W'(MAX_VERTICES + 1));
                    cmd.clear_face = 1'b1;
                    cnt_next       = '0;
                    inv_next       = 1'b0;
                    last_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

endmodule

FILE: sv/pfa_dp.sv
module pfa_dp
    import pfa_pkg::*;
#(
    parameter int COORD_BITS = PFA_COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pfa_cmd_t                       cmd,
    input  logic signed [COORD_BITS-1:0]   x_coord,
    input  logic signed [COORD_BITS-1:0]   y_coord,
    input  logic signed [COORD_BITS-1:0]   z_coord,
    output logic        [PFA_ACC_BITS-1:0] twice_area,
    output logic signed [PFA_ACC_BITS-1:0] normal_x,
    output logic signed [PFA_ACC_BITS-1:0] normal_y,
    output logic signed [PFA_ACC_BITS-1:0] normal_z,
    output logic                           degenerate,
    output logic                           vertex_overflow
);

    localparam int DIF_W  = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIF_W;
    localparam int EXT_W  = (PROD_W + 1 > PFA_ACC_BITS) ? PROD_W + 1 : PFA_ACC_BITS;

    logic signed [COORD_BITS-1:0]   cur_w    [3];
    logic signed [COORD_BITS-1:0]   anchor_reg [3];
    logic signed [COORD_BITS-1:0]   prev_reg [3];
    logic signed [DIF_W-1:0]        e1_reg   [3];
    logic signed [DIF_W-1:0]        e2_reg   [3];
    logic signed [PROD_W-1:0]       prod_reg [6];
    logic signed [EXT_W-1:0]        cdiff_w  [3];
    logic        [PFA_ACC_BITS-1:0] cross_w  [3];
    logic        [PFA_ACC_BITS-1:0] acc_reg  [3];
    logic        [PFA_ACC_BITS-1:0] mag_reg  [3];

    pfa_pp_sel_t                    pp_sel_w;
    logic        [PFA_ACC_BITS-1:0] pp_mag_w;
    logic        [PFA_HALF_W-1:0]   opa_w, opb_w;
    logic        [PFA_ACC_BITS-1:0] pp_reg;
    pfa_part_t                      pp_part_reg;
    logic        [PFA_SUM_W-1:0]    pp_shift_w;
    logic        [PFA_SUM_W-1:0]    sum_reg;
    logic        [PFA_REM_W-1:0]    rem_reg;
    logic        [PFA_REM_W-1:0]    rem_sh_w, trial_w;
    logic        [PFA_ACC_BITS-1:0] root_reg;

    logic        [PFA_ACC_BITS-1:0] twice_area_reg;
    logic        [PFA_ACC_BITS-1:0] normal_reg [3];
    logic                           degenerate_reg;
    logic                           overflow_reg;

    assign cur_w[0] = x_coord;
    assign cur_w[1] = y_coord;
    assign cur_w[2] = z_coord;

    // cross product components from the registered edge products
    always_comb begin
        cdiff_w[0] = EXT_W'(prod_reg[0]) - EXT_W'(prod_reg[1]);
        cdiff_w[1] = EXT_W'(prod_reg[2]) - EXT_W'(prod_reg[3]);
        cdiff_w[2] = EXT_W'(prod_reg[4]) - EXT_W'(prod_reg[5]);
        for (int i = 0; i < 3; i++)
            cross_w[i] = cdiff_w[i][PFA_ACC_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                acc_reg[i] <= '0;
        end
        else if (cmd.clear_face)
        begin
            for (int i = 0; i < 3; i++)
                acc_reg[i] <= '0;
        end
        else if (cmd.acc)
        begin
            for (int i = 0; i < 3; i++)
                acc_reg[i] <= acc_reg[i] + cross_w[i];
        end
    end

    always_ff @(posedge clk) begin
        for (int i = 0; i < 3; i++)
        begin
            if (cmd.take_anchor)
                anchor_reg[i] <= cur_w[i];
            if (cmd.take_prev)
                prev_reg[i] <= cur_w[i];
            if (cmd.take_diff)
            begin
                e1_reg[i] <= DIF_W'(prev_reg[i]) - DIF_W'(anchor_reg[i]);
                e2_reg[i] <= DIF_W'(cur_w[i]) - DIF_W'(anchor_reg[i]);
            end
        end
        if (cmd.mul)
        begin
            prod_reg[0] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[2]);
            prod_reg[1] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[1]);
            prod_reg[2] <= PROD_W'(e1_reg[2]) * PROD_W'(e2_reg[0]);
            prod_reg[3] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[2]);
            prod_reg[4] <= PROD_W'(e1_reg[0]) * PROD_W'(e2_reg[1]);
            prod_reg[5] <= PROD_W'(e1_reg[1]) * PROD_W'(e2_reg[0]);
        end
    end

    // squared length from half-width partial products
    always_comb begin
        pp_sel_w = pfa_pp_decode(cmd.sq_sel);
        pp_mag_w = mag_reg[pp_sel_w.comp];
        case (pp_sel_w.part)
            PART_LL:
            begin
                opa_w = pp_mag_w[PFA_HALF_W-1:0];
                opb_w = pp_mag_w[PFA_HALF_W-1:0];
            end
            PART_HL:
            begin
                opa_w = pp_mag_w[PFA_ACC_BITS-1:PFA_HALF_W];
                opb_w = pp_mag_w[PFA_HALF_W-1:0];
            end
            default:
            begin
                opa_w = pp_mag_w[PFA_ACC_BITS-1:PFA_HALF_W];
                opb_w = pp_mag_w[PFA_ACC_BITS-1:PFA_HALF_W];
            end
        endcase
    end

    always_comb begin
        case (pp_part_reg)
            PART_LL: pp_shift_w = PFA_SUM_W'(pp_reg);
            // cross term counts twice
            PART_HL: pp_shift_w = PFA_SUM_W'(pp_reg) << (PFA_HALF_W + 1);
            default: pp_shift_w = PFA_SUM_W'(pp_reg) << (2 * PFA_HALF_W);
        endcase
    end

    // restoring square root, two radicand bits per step
    assign rem_sh_w = {rem_reg[PFA_REM_W-3:0], sum_reg[PFA_SUM_W-1 -: 2]};
    assign trial_w  = PFA_REM_W'({root_reg, 2'b01});

    always_ff @(posedge clk) begin
        if (cmd.mag_load)
        begin
            for (int i = 0; i < 3; i++)
                mag_reg[i] <= acc_reg[i][PFA_ACC_BITS-1] ? '0 - acc_reg[i] : acc_reg[i];
        end
        if (cmd.sq_mul)
        begin
            pp_reg      <= PFA_ACC_BITS'(opa_w) * PFA_ACC_BITS'(opb_w);
            pp_part_reg <= pp_sel_w.part;
        end
        if (cmd.sq_clear)
        begin
            sum_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sq_add)
            sum_reg <= sum_reg + pp_shift_w;
        else if (cmd.rt_step)
        begin
            sum_reg <= sum_reg << 2;
            if (rem_sh_w >= trial_w)
            begin
                rem_reg  <= rem_sh_w - trial_w;
                root_reg <= {root_reg[PFA_ACC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh_w;
                root_reg <= {root_reg[PFA_ACC_BITS-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            twice_area_reg <= cmd.degenerate ? '0 : root_reg;
            for (int i = 0; i < 3; i++)
                normal_reg[i] <= cmd.degenerate ? '0 : acc_reg[i];
            degenerate_reg <= cmd.degenerate;
            overflow_reg   <= cmd.overflow;
        end
    end

    assign twice_area      = twice_area_reg;
    assign normal_x        = normal_reg[0];
    assign normal_y        = normal_reg[1];
    assign normal_z        = normal_reg[2];
    assign degenerate      = degenerate_reg;
    assign vertex_overflow = overflow_reg;

endmodule

FILE: sv/polygon_face_area.sv
// channel | role   | handshake           | payload
// in      | vertex | in_valid / in_ready | x_coord y_coord z_coord last_vertex face_invalid
// out     | face   | out_valid/out_ready | twice_area normal_x/y/z degenerate vertex_overflow
//
// a vertex that adds a fan triangle passes through accept and the cross product multiply;
// the others are only accepted. the last vertex holds the input off through multiply,
// accumulate, the sum of squares on one 21x21 multiplier, 42 square root steps
// and the output load; a degenerate face skips the sum of squares and the root.
// the output register parts the sides: the next face streams in while a result waits,
// and only the load of the following result stalls on out_ready.
// reset clears the controller, the running normal and the output valid.
module polygon_face_area
    import pfa_pkg::*;
#(
    parameter int MAX_VERTICES = PFA_MAX_VERTICES_DEF,
    parameter int COORD_BITS   = PFA_COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [COORD_BITS-1:0]   x_coord,
    input  logic signed [COORD_BITS-1:0]   y_coord,
    input  logic signed [COORD_BITS-1:0]   z_coord,
    input  logic                           last_vertex,
    input  logic                           face_invalid,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic        [PFA_ACC_BITS-1:0] twice_area,
    output logic signed [PFA_ACC_BITS-1:0] normal_x,
    output logic signed [PFA_ACC_BITS-1:0] normal_y,
    output logic signed [PFA_ACC_BITS-1:0] normal_z,
    output logic                           degenerate,
    output logic                           vertex_overflow
);

    pfa_cmd_t cmd;

    pfa_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .last_vertex  (last_vertex),
        .face_invalid (face_invalid),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cmd          (cmd)
    );

    pfa_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .x_coord         (x_coord),
        .y_coord         (y_coord),
        .z_coord         (z_coord),
        .twice_area      (twice_area),
        .normal_x        (normal_x),
        .normal_y        (normal_y),
        .normal_z        (normal_z),
        .degenerate      (degenerate),
        .vertex_overflow (vertex_overflow)
    );

endmodule

FILE: sv/pfa_checker.sv
`include "polygon_face_area_defines.svh"

module pfa_checker
    import pfa_pkg::*;
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           last_vertex,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic        [PFA_ACC_BITS-1:0] twice_area,
    input logic signed [PFA_ACC_BITS-1:0] normal_x,
    input logic signed [PFA_ACC_BITS-1:0] normal_y,
    input logic signed [PFA_ACC_BITS-1:0] normal_z,
    input logic                           degenerate
);

    // a stalled result holds its area
    `PFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(twice_area))

    // degenerate faces report nothing but the flags
    `PFA_ASSERT_NOW(a_degen_zero, out_valid && degenerate, twice_area == 0 && normal_x == 0 && normal_y == 0 && normal_z == 0)

    // the face end blocks input while the result is worked out
    `PFA_ASSERT_NEXT(a_last_blocks, in_valid && in_ready && last_vertex, !in_ready)

    // a new result is only loaded while input is held off
    `PFA_ASSERT_NOW(a_load_busy, $rose(out_valid), $past(!in_ready))

endmodule

bind polygon_face_area pfa_checker u_pfa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .last_vertex (last_vertex),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .twice_area  (twice_area),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .degenerate  (degenerate)
);
